// ===== rtl/psq_pkg.sv =====
// psq_pkg: shared types and constants for the pending signal queue
// depends on nothing
`timescale 1ns / 1ps

package psq_pkg;

  localparam int NUM_SIGNALS_DEF  = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = 6;
  localparam int CNT_W      = 7;
  localparam int SIG_W      = 6;
  localparam int SIG_IN_W   = 8;
  localparam int PAY_IN_W   = 32;
  localparam int MASK_W     = 64;
  localparam int STAT_W     = 3;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_NO_TABLE = 3'd1,
    STAT_INVALID  = 3'd2,
    STAT_PENDING  = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef enum logic {
    FUNC_SEND  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  typedef enum logic {
    REG_TABLE_PRESENT = 1'b0,
    REG_BLOCK_BITS    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic commit;
  } ctl_t;

endpackage

// ===== rtl/psq_ctrl.sv =====
// psq_ctrl: request sequencer, capture then decide then commit and reply
// depends on psq_pkg
`timescale 1ns / 1ps

module psq_ctrl
  import psq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_REPLY;
      ST_REPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    ctl.capture = 1'b0;
    ctl.decide  = 1'b0;
    ctl.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        ctl.capture = start;
      end
      ST_READ: begin
        ctl.decide = 1'b1;
      end
      ST_REPLY: begin
        done       = 1'b1;
        ctl.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/psq_datapath.sv =====
// psq_datapath: config registers, pending bits, entry memory and fifo pointers
// depends on psq_pkg
`timescale 1ns / 1ps

module psq_datapath
  import psq_pkg::*;
#(
  parameter int NUM_SIGNALS  = NUM_SIGNALS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl,
  input  logic                func,
  input  logic [SIG_IN_W-1:0] sig,
  input  logic [PAY_IN_W-1:0] payload,
  input  logic                cfg_wr,
  input  logic                cfg_index,
  input  logic [MASK_W-1:0]   cfg_data,
  output logic [STAT_W-1:0]   status,
  output logic [SIG_W-1:0]    out_sig,
  output logic [PAY_IN_W-1:0] out_payload
);

  localparam int PW      = (PAYLOAD_BITS < PAY_IN_W) ? PAYLOAD_BITS : PAY_IN_W;
  localparam int ENTRY_W = SIG_W + PW;

  logic                   table_present;
  logic [MASK_W-1:0]      block_bits;
  logic [NUM_SIGNALS-1:0] pending;
  logic [PTR_W-1:0]       head;
  logic [PTR_W-1:0]       tail;
  logic [CNT_W-1:0]       count;

  logic                   req_func;
  logic [SIG_IN_W-1:0]    req_sig;
  logic [PW-1:0]          req_pay;

  status_t                dec_status;
  logic                   dec_push;
  logic                   dec_pop;
  logic                   dec_set;

  logic [ENTRY_W-1:0]     mem [FIFO_DEPTH];
  logic [ENTRY_W-1:0]     rd_q;

  status_t                stat_next;
  logic                   push_next;
  logic                   pop_next;
  logic                   set_next;
  logic [SIG_W-1:0]       req_idx;
  logic [MASK_W-1:0]      pend_wide;
  logic [MASK_W-1:0]      req_bit;
  logic [MASK_W-1:0]      pop_bit;
  logic [SIG_W-1:0]       rd_sig;

  assign req_idx   = req_sig[SIG_W-1:0];
  assign pend_wide = MASK_W'(pending);
  assign req_bit   = MASK_W'(1) << req_idx;
  assign rd_sig    = rd_q[ENTRY_W-1 -: SIG_W];
  assign pop_bit   = MASK_W'(1) << rd_sig;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_present <= 1'b0;
      block_bits    <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_TABLE_PRESENT: table_present <= cfg_data[0];
        REG_BLOCK_BITS:    block_bits    <= cfg_data;
        default:           table_present <= table_present;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_func <= func;
      req_sig  <= sig;
      req_pay  <= payload[PW-1:0];
    end
  end

  // request decision
  always_comb begin
    stat_next = STAT_OK;
    push_next = 1'b0;
    pop_next  = 1'b0;
    set_next  = 1'b0;
    if (!table_present) begin
      stat_next = STAT_NO_TABLE;
    end else if (req_func == FUNC_SEND) begin
      if (req_sig[SIG_IN_W-1] || (req_sig >= SIG_IN_W'(NUM_SIGNALS))) begin
        stat_next = STAT_INVALID;
      end else if (block_bits[req_idx]) begin
        set_next = 1'b1;
      end else if (pend_wide[req_idx] || (count >= CNT_W'(FIFO_DEPTH))) begin
        stat_next = STAT_PENDING;
      end else begin
        push_next = 1'b1;
        set_next  = 1'b1;
      end
    end else begin
      if (count == '0) begin
        stat_next = STAT_EMPTY;
      end else begin
        pop_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_status <= STAT_OK;
      dec_push   <= 1'b0;
      dec_pop    <= 1'b0;
      dec_set    <= 1'b0;
    end else if (ctl.decide) begin
      dec_status <= stat_next;
      dec_push   <= push_next;
      dec_pop    <= pop_next;
      dec_set    <= set_next;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (ctl.commit && dec_push) begin
      mem[tail] <= {req_idx, req_pay};
    end
    if (ctl.decide) begin
      rd_q <= mem[head];
    end
  end

  // queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else if (ctl.commit) begin
      if (dec_set) begin
        pending <= pending | req_bit[NUM_SIGNALS-1:0];
      end
      if (dec_push) begin
        tail  <= tail + PTR_W'(1);
        count <= count + CNT_W'(1);
      end
      if (dec_pop) begin
        pending <= pending & ~pop_bit[NUM_SIGNALS-1:0];
        head    <= head + PTR_W'(1);
        count   <= count - CNT_W'(1);
      end
    end
  end

  assign status      = dec_status;
  assign out_sig     = dec_pop ? rd_sig : '0;
  assign out_payload = dec_pop ? PAY_IN_W'(rd_q[PW-1:0]) : '0;

endmodule

// ===== rtl/pending_signal_queue.sv =====
// pending_signal_queue: top level, sequencer plus datapath
// depends on psq_pkg, psq_ctrl, psq_datapath
//
// channel   direction  handshake            payload
// request   in         start, busy          func, sig, payload
// result    out        done strobe          status, out_sig, out_payload
// config    in         cfg_valid, cfg_ready cfg_index, cfg_data
//
// each request passes in order through capture, memory read and decision, then commit and reply
// the memory read port of the entry store sets the read-then-commit sequence
// start is taken only while busy is low; done is high for exactly one cycle
// synchronous active-high reset clears config, pending bits and fifo pointers
// the receiver cannot stall results; config writes are always ready
`timescale 1ns / 1ps

module pending_signal_queue
  import psq_pkg::*;
#(
  parameter int NUM_SIGNALS  = NUM_SIGNALS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic [SIG_IN_W-1:0] sig,
  input  logic [PAY_IN_W-1:0] payload,
  output logic                done,
  output logic [STAT_W-1:0]   status,
  output logic [SIG_W-1:0]    out_sig,
  output logic [PAY_IN_W-1:0] out_payload,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [MASK_W-1:0]   cfg_data
);

  ctl_t ctl;

  assign cfg_ready = 1'b1;

  psq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  psq_datapath #(
    .NUM_SIGNALS  (NUM_SIGNALS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .func        (func),
    .sig         (sig),
    .payload     (payload),
    .cfg_wr      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .out_sig     (out_sig),
    .out_payload (out_payload)
  );

endmodule
